FILE: hdl/dpsp_pkg.sv
// Shared types and constants of the dual pedal sensor plausibility checker.
// No dependencies; every other file but dpsp_div imports this package.
`default_nettype none

package dpsp_pkg;

	localparam int PCT_W      = 7;
	localparam int DZ_W       = 6;
	localparam int LIM_W      = 7;
	localparam int CONFIRM_W  = 4;
	localparam int HOLD_W     = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

	localparam int BOUND_MAX_RESET = 2000;
	localparam int BOUND_MIN_RESET = 600;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_DEADZONE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MISMATCH    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CONFIRM     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BRAKE_LIMIT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD        = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TESTING     = 3'd5;

	typedef struct packed {
		logic [DZ_W-1:0]      deadzone_percent;
		logic [LIM_W-1:0]     mismatch_limit;
		logic [CONFIRM_W-1:0] confirm_count;
		logic [LIM_W-1:0]     brake_pedal_limit;
		logic [HOLD_W-1:0]    hold_time_ms;
		logic                 testing_mode;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		deadzone_percent:  6'd8,
		mismatch_limit:    7'd10,
		confirm_count:     4'd2,
		brake_pedal_limit: 7'd5,
		hold_time_ms:      16'd500,
		testing_mode:      1'b0
	};

	// lane status back to the top level
	typedef struct packed {
		logic             done;
		logic [PCT_W-1:0] pct;
	} lane_res_t;

	// step request from the top level to the merge stage
	typedef struct packed {
		logic step;
		logic brake;
		logic rst;
	} merge_req_t;

	typedef struct packed {
		logic             implausible;
		logic [PCT_W-1:0] pedal_out;
		logic [PCT_W-1:0] average_percent;
		logic [PCT_W-1:0] percent_a;
		logic [PCT_W-1:0] percent_b;
		logic             mismatch_flag;
		logic             brake_flag;
		logic             calibrating;
	} out_res_t;

endpackage

`default_nettype wire

FILE: hdl/dpsp_chan_if.sv
// Valid/ready channel interfaces for sample beats and result beats.
// Depends on dpsp_pkg for the percent width.
`default_nettype none

interface dpsp_in_if #(
	parameter int SAMPLE_BITS = 12,
	parameter int TIME_BITS   = 32
);
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] sample_a;
	logic [SAMPLE_BITS-1:0] sample_b;
	logic                   brake_pressed;
	logic                   reset_pressed;
	logic [TIME_BITS-1:0]   now_ms;

	modport source (output valid, sample_a, sample_b, brake_pressed, reset_pressed, now_ms,
		input ready);
	modport sink (input valid, sample_a, sample_b, brake_pressed, reset_pressed, now_ms,
		output ready);
endinterface

interface dpsp_out_if import dpsp_pkg::*;;
	logic             valid;
	logic             ready;
	logic             implausible;
	logic [PCT_W-1:0] pedal_out;
	logic [PCT_W-1:0] average_percent;
	logic [PCT_W-1:0] percent_a;
	logic [PCT_W-1:0] percent_b;
	logic             mismatch_flag;
	logic             brake_flag;
	logic             calibrating;

	modport source (output valid, implausible, pedal_out, average_percent, percent_a,
		percent_b, mismatch_flag, brake_flag, calibrating, input ready);
	modport sink (input valid, implausible, pedal_out, average_percent, percent_a,
		percent_b, mismatch_flag, brake_flag, calibrating, output ready);
endinterface

`default_nettype wire

FILE: hdl/dpsp_div.sv
// Restoring divider, two quotient bits per cycle.
// Standalone; NUM_BITS must be even. Results hold until the next start.
`default_nettype none

module dpsp_div #(
	parameter int NUM_BITS = 20,
	parameter int DEN_BITS = 12
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic [NUM_BITS-1:0] num,
	input  wire logic [DEN_BITS-1:0] den,
	output logic                     done,
	output logic [NUM_BITS-1:0]      quo
);

	localparam int STEPS = NUM_BITS / 2;
	localparam int CNT_W = $clog2(STEPS + 1);

	logic [DEN_BITS-1:0] rem_q;
	logic [NUM_BITS-1:0] quo_q;
	logic [DEN_BITS-1:0] den_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                busy_q;
	logic                done_q;

	logic [DEN_BITS-1:0] rem_w;
	logic [NUM_BITS-1:0] quo_w;
	logic [DEN_BITS:0]   trial_w;
	logic                qbit_w;

	always_comb begin
		rem_w   = rem_q;
		quo_w   = quo_q;
		trial_w = '0;
		qbit_w  = 1'b0;
		for (int i = 0; i < 2; i++) begin
			trial_w = {rem_w, quo_w[NUM_BITS-1]};
			if (trial_w >= {1'b0, den_q}) begin
				trial_w = trial_w - {1'b0, den_q};
				qbit_w  = 1'b1;
			end else begin
				qbit_w = 1'b0;
			end
			rem_w = trial_w[DEN_BITS-1:0];
			quo_w = {quo_w[NUM_BITS-2:0], qbit_w};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= rem_w;
			quo_q <= quo_w;
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

`default_nettype wire

FILE: hdl/dpsp_lane.sv
// One sensor lane: bound tracking with confirmation, deadzone thresholds and
// the 0..100 percent mapping. Depends on dpsp_pkg and dpsp_div.
`default_nettype none

module dpsp_lane import dpsp_pkg::*; #(
	parameter int SAMPLE_BITS = 12
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	input  wire logic [SAMPLE_BITS-1:0] sample,
	input  wire cfg_t                   cfg,
	output lane_res_t                   res
);

	localparam int NW   = ((SAMPLE_BITS + 8) / 2) * 2;
	localparam int PW   = SAMPLE_BITS + DZ_W;
	// floor(prod / 100) as (prod * QM) >> QK, exact for every prod below 2^PW
	localparam int QK   = PW + 7;
	localparam int QM_W = PW + 1;
	localparam int QP_W = PW + QM_W;
	localparam logic [QM_W-1:0] QM = QM_W'(((1 << QK) + 99) / 100);
	localparam logic [SAMPLE_BITS-1:0] MAX_RST = SAMPLE_BITS'(BOUND_MAX_RESET);
	localparam logic [SAMPLE_BITS-1:0] MIN_RST = SAMPLE_BITS'(BOUND_MIN_RESET);

	typedef enum logic [5:0] {
		L_IDLE = 6'b000001,
		L_PROD = 6'b000010,
		L_CUT  = 6'b000100,
		L_THR  = 6'b001000,
		L_PCT  = 6'b010000,
		L_PCTW = 6'b100000
	} lane_state_t;

	lane_state_t state_q;

	logic [SAMPLE_BITS-1:0] x_q;
	logic [SAMPLE_BITS-1:0] bmax_q;
	logic [SAMPLE_BITS-1:0] bmin_q;
	logic [CONFIRM_W-1:0]   over_q;
	logic [CONFIRM_W-1:0]   under_q;
	logic [PW-1:0]          prod_q;
	logic [SAMPLE_BITS-1:0] cut_lo_q;
	logic [SAMPLE_BITS-1:0] hi_q;
	logic [SAMPLE_BITS-1:0] lo_q;
	logic [PCT_W-1:0]       pct_q;
	logic                   done_q;

	logic [SAMPLE_BITS-1:0] bmax_n;
	logic [SAMPLE_BITS-1:0] bmin_n;
	logic [CONFIRM_W-1:0]   over_n;
	logic [CONFIRM_W-1:0]   under_n;

	logic [SAMPLE_BITS-1:0] span;
	logic [PW-1:0]          prod;
	logic [QP_W-1:0]        quot;
	logic [SAMPLE_BITS-1:0] cut_lo;
	logic [PW-1:0]          cut_back;
	logic [SAMPLE_BITS:0]   cut_hi;
	logic [SAMPLE_BITS-1:0] hi_w;
	logic [SAMPLE_BITS-1:0] lo_w;
	logic [NW-1:0]          pct_num;
	logic [PCT_W-1:0]       pct_w;

	logic                   div_start;
	logic [NW-1:0]          div_num;
	logic [SAMPLE_BITS-1:0] div_den;
	logic                   div_done;
	logic [NW-1:0]          div_quo;

	// bound tracking on the incoming sample
	always_comb begin
		bmax_n  = bmax_q;
		bmin_n  = bmin_q;
		over_n  = '0;
		under_n = '0;
		if (sample > bmax_q) begin
			if (over_q >= cfg.confirm_count) begin
				bmax_n = sample;
			end else begin
				over_n = over_q + CONFIRM_W'(1);
			end
		end else if (sample < bmin_q) begin
			if (under_q >= cfg.confirm_count) begin
				bmin_n = sample;
			end else begin
				under_n = under_q + CONFIRM_W'(1);
			end
		end
	end

	always_comb begin
		span     = (bmax_q >= bmin_q) ? (bmax_q - bmin_q) : '0;
		prod     = PW'(span) * PW'(cfg.deadzone_percent);
		quot     = QP_W'(prod_q) * QP_W'(QM);
		cut_lo   = quot[QK +: SAMPLE_BITS];
		cut_back = PW'(cut_lo_q) * PW'(PCT_FULL);
		// round the high cut up when the division leaves a remainder
		cut_hi   = {1'b0, cut_lo_q} + (SAMPLE_BITS+1)'(cut_back != prod_q);
		hi_w     = ({1'b0, bmax_q} >= cut_hi) ? (bmax_q - cut_hi[SAMPLE_BITS-1:0]) : '0;
		lo_w     = bmin_q + cut_lo_q;
		pct_num  = NW'(x_q - lo_q) * NW'(PCT_FULL);
		if (x_q <= lo_q) begin
			pct_w = '0;
		end else if (x_q >= hi_q) begin
			pct_w = PCT_FULL;
		end else begin
			pct_w = div_quo[PCT_W-1:0];
		end
	end

	// the divider only serves the percent between the thresholds
	assign div_start = (state_q == L_PCT);
	assign div_num   = pct_num;
	assign div_den   = hi_q - lo_q;

	dpsp_div #(
		.NUM_BITS (NW),
		.DEN_BITS (SAMPLE_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= L_IDLE;
			bmax_q  <= MAX_RST;
			bmin_q  <= MIN_RST;
			over_q  <= '0;
			under_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				L_IDLE: begin
					if (start) begin
						bmax_q  <= bmax_n;
						bmin_q  <= bmin_n;
						over_q  <= over_n;
						under_q <= under_n;
						state_q <= L_PROD;
					end
				end
				L_PROD: begin
					state_q <= L_CUT;
				end
				L_CUT: begin
					state_q <= L_THR;
				end
				L_THR: begin
					state_q <= L_PCT;
				end
				L_PCT: begin
					state_q <= L_PCTW;
				end
				L_PCTW: begin
					if (div_done) begin
						done_q  <= 1'b1;
						state_q <= L_IDLE;
					end
				end
				default: begin
					state_q <= L_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == L_IDLE && start) begin
			x_q <= sample;
		end
		if (state_q == L_PROD) begin
			prod_q <= prod;
		end
		if (state_q == L_CUT) begin
			cut_lo_q <= cut_lo;
		end
		if (state_q == L_THR) begin
			hi_q <= hi_w;
			lo_q <= lo_w;
		end
		if (state_q == L_PCTW && div_done) begin
			pct_q <= pct_w;
		end
	end

	assign res.done = done_q;
	assign res.pct  = pct_q;

endmodule

`default_nettype wire

FILE: hdl/dpsp_merge.sv
// Merge stage: averages the lane percents, keeps the calibration flag and the
// mismatch and brake flags with their hold-off stamps, and forms the result. Depends on dpsp_pkg.
`default_nettype none

module dpsp_merge import dpsp_pkg::*; #(
	parameter int TIME_BITS = 32
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire merge_req_t           req,
	input  wire logic [TIME_BITS-1:0] now_ms,
	input  wire logic [PCT_W-1:0]     pct_a,
	input  wire logic [PCT_W-1:0]     pct_b,
	input  wire cfg_t                 cfg,
	output out_res_t                  res
);

	logic                 cal_q;
	logic                 mis_q;
	logic                 brk_q;
	logic [TIME_BITS-1:0] mis_stamp_q;
	logic [TIME_BITS-1:0] brk_stamp_q;

	logic                 cal_n;
	logic                 mis_n;
	logic                 brk_n;
	logic [PCT_W:0]       sum;
	logic [PCT_W-1:0]     avg;
	logic [PCT_W-1:0]     diff;
	logic                 mis_set;
	logic                 brk_set;
	logic [TIME_BITS-1:0] mis_elapsed;
	logic [TIME_BITS-1:0] brk_elapsed;
	logic                 imp;

	always_comb begin
		sum         = {1'b0, pct_a} + {1'b0, pct_b};
		avg         = sum[PCT_W:1];
		diff        = (pct_a >= pct_b) ? (pct_a - pct_b) : (pct_b - pct_a);
		mis_set     = diff > cfg.mismatch_limit;
		brk_set     = req.brake && (avg >= cfg.brake_pedal_limit);
		mis_elapsed = now_ms - mis_stamp_q;
		brk_elapsed = now_ms - brk_stamp_q;
		// the reset switch acts before this beat's checks
		cal_n = cal_q && !req.rst;
		mis_n = mis_set || (mis_q && !req.rst && !(mis_elapsed > TIME_BITS'(cfg.hold_time_ms)));
		brk_n = brk_set || (brk_q && !req.rst && !(brk_elapsed > TIME_BITS'(cfg.hold_time_ms)));
		imp   = cal_n || mis_n || brk_n || cfg.testing_mode;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q       <= 1'b1;
			mis_q       <= 1'b0;
			brk_q       <= 1'b0;
			mis_stamp_q <= '0;
			brk_stamp_q <= '0;
		end else if (req.step) begin
			cal_q <= cal_n;
			mis_q <= mis_n;
			brk_q <= brk_n;
			if (mis_set) begin
				mis_stamp_q <= now_ms;
			end
			if (brk_set) begin
				brk_stamp_q <= now_ms;
			end
		end
	end

	assign res.implausible     = imp;
	assign res.pedal_out       = imp ? '0 : avg;
	assign res.average_percent = avg;
	assign res.percent_a       = pct_a;
	assign res.percent_b       = pct_b;
	assign res.mismatch_flag   = mis_n;
	assign res.brake_flag      = brk_n;
	assign res.calibrating     = cal_n;

endmodule

`default_nettype wire

FILE: hdl/dual_pedal_sensor_plausibility.sv
// Top level of the dual pedal sensor plausibility checker.
// Depends on dpsp_pkg, dpsp_chan_if, dpsp_lane and dpsp_merge.
//
// Channel     | Direction | Beat carries
// ------------+-----------+-----------------------------------------------
// sample_ch   | in        | sample_a, sample_b, brake, reset, now_ms
// result_ch   | out       | flags, percents, average, masked pedal value
// cfg_*       | in        | write enable, register index, data (no wait)
//
// One item is in work at a time. From the accepting edge to the result beat
// the item passes the bound, deadzone and threshold work, then the percent
// pass through each lane's 2-bit-per-cycle divider, then the merge and the
// output register, which waits while the result side stalls.
// A finished result waits in the output register while the next beat enters.
// Reset loads the calibration bounds and configuration defaults at once.
`default_nettype none

module dual_pedal_sensor_plausibility import dpsp_pkg::*; #(
	parameter int SAMPLE_BITS = 12,
	parameter int TIME_BITS   = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	dpsp_in_if.sink                    sample_ch,
	dpsp_out_if.source                 result_ch,
	input  wire logic                  cfg_wen,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	typedef enum logic [2:0] {
		T_IDLE  = 3'b001,
		T_RUN   = 3'b010,
		T_MERGE = 3'b100
	} top_state_t;

	top_state_t           state_q;
	cfg_t                 cfg_q;
	logic                 brake_q;
	logic                 rst_q;
	logic [TIME_BITS-1:0] now_q;
	out_res_t             out_q;
	logic                 out_valid_q;

	logic       in_beat;
	logic       out_free;
	lane_res_t  lane_a;
	lane_res_t  lane_b;
	merge_req_t mreq;
	out_res_t   mres;

	assign sample_ch.ready = (state_q == T_IDLE);
	assign in_beat         = sample_ch.valid && sample_ch.ready;
	assign out_free        = !out_valid_q || result_ch.ready;

	assign mreq.step  = (state_q == T_MERGE) && out_free;
	assign mreq.brake = brake_q;
	assign mreq.rst   = rst_q;

	dpsp_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_a (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (in_beat),
		.sample (sample_ch.sample_a),
		.cfg    (cfg_q),
		.res    (lane_a)
	);

	dpsp_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_b (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (in_beat),
		.sample (sample_ch.sample_b),
		.cfg    (cfg_q),
		.res    (lane_b)
	);

	dpsp_merge #(.TIME_BITS(TIME_BITS)) u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.now_ms (now_q),
		.pct_a  (lane_a.pct),
		.pct_b  (lane_b.pct),
		.cfg    (cfg_q),
		.res    (mres)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_DEADZONE:    cfg_q.deadzone_percent  <= cfg_data[DZ_W-1:0];
				REG_MISMATCH:    cfg_q.mismatch_limit    <= cfg_data[LIM_W-1:0];
				REG_CONFIRM:     cfg_q.confirm_count     <= cfg_data[CONFIRM_W-1:0];
				REG_BRAKE_LIMIT: cfg_q.brake_pedal_limit <= cfg_data[LIM_W-1:0];
				REG_HOLD:        cfg_q.hold_time_ms      <= cfg_data[HOLD_W-1:0];
				REG_TESTING:     cfg_q.testing_mode      <= cfg_data[0];
				default:         cfg_q                   <= cfg_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= T_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (mreq.step) begin
				out_valid_q <= 1'b1;
			end else if (result_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				T_IDLE: begin
					if (in_beat) begin
						state_q <= T_RUN;
					end
				end
				T_RUN: begin
					// lanes run in lock step
					if (lane_a.done && lane_b.done) begin
						state_q <= T_MERGE;
					end
				end
				T_MERGE: begin
					if (out_free) begin
						state_q <= T_IDLE;
					end
				end
				default: begin
					state_q <= T_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			brake_q <= sample_ch.brake_pressed;
			rst_q   <= sample_ch.reset_pressed;
			now_q   <= sample_ch.now_ms;
		end
		if (mreq.step) begin
			out_q <= mres;
		end
	end

	assign result_ch.valid           = out_valid_q;
	assign result_ch.implausible     = out_q.implausible;
	assign result_ch.pedal_out       = out_q.pedal_out;
	assign result_ch.average_percent = out_q.average_percent;
	assign result_ch.percent_a       = out_q.percent_a;
	assign result_ch.percent_b       = out_q.percent_b;
	assign result_ch.mismatch_flag   = out_q.mismatch_flag;
	assign result_ch.brake_flag      = out_q.brake_flag;
	assign result_ch.calibrating     = out_q.calibrating;

endmodule

`default_nettype wire

FILE: hdl/dpsp_checker.sv
// Port-level checks on the plausibility checker's result beats, and the bind
// that attaches them to the top level. Depends on dpsp_pkg.
`default_nettype none

module dpsp_checker import dpsp_pkg::*; (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             in_valid,
	input wire logic             in_ready,
	input wire logic             out_valid,
	input wire logic             out_ready,
	input wire logic             implausible,
	input wire logic [PCT_W-1:0] pedal_out,
	input wire logic [PCT_W-1:0] average_percent,
	input wire logic             mismatch_flag,
	input wire logic             brake_flag,
	input wire logic             calibrating
);

	logic       in_beat;
	logic       out_beat;
	logic [1:0] pend_q;
	logic       cal_cleared_q;

	assign in_beat  = in_valid && in_ready;
	assign out_beat = out_valid && out_ready;

	// track beats taken but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q        <= '0;
			cal_cleared_q <= 1'b0;
		end else begin
			pend_q <= pend_q + 2'(in_beat) - 2'(out_beat);
			if (out_beat && !calibrating) begin
				cal_cleared_q <= 1'b1;
			end
		end
	end

	a_masked_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (implausible ? (pedal_out == '0) : (pedal_out == average_percent)))
		else $error("pedal_out disagrees with implausible and average_percent");

	a_flags_imply: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (mismatch_flag || brake_flag || calibrating) |-> implausible)
		else $error("flag set without implausible");

	a_cal_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && calibrating |-> !cal_cleared_q)
		else $error("calibrating came back after it had cleared");

	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pend_q != 2'd0))
		else $error("result beat without an accepted sample beat");

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result valid dropped while stalled");

endmodule

bind dual_pedal_sensor_plausibility dpsp_checker u_dpsp_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (sample_ch.valid),
	.in_ready        (sample_ch.ready),
	.out_valid       (result_ch.valid),
	.out_ready       (result_ch.ready),
	.implausible     (result_ch.implausible),
	.pedal_out       (result_ch.pedal_out),
	.average_percent (result_ch.average_percent),
	.mismatch_flag   (result_ch.mismatch_flag),
	.brake_flag      (result_ch.brake_flag),
	.calibrating     (result_ch.calibrating)
);

`default_nettype wire

FILE: test/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for dual_pedal_sensor_plausibility: drives sample beats,
// predicts each result beat in place and compares them field by field.
// Depends on dpsp_pkg, dpsp_chan_if and the RTL of the block.

module testbench;
	import dpsp_pkg::*;

	localparam int SAMPLE_BITS     = 12;
	localparam int TIME_BITS       = 32;
	localparam int SAMPLE_MAX      = (1 << SAMPLE_BITS) - 1;
	localparam int HALF_PERIOD     = 5;
	localparam int RESET_CYCLES    = 10;
	localparam int IDLE_PCT        = 38;
	localparam int PHASES          = 8;
	localparam int BEATS_PER_PHASE = 230;
	localparam int STALL_CYCLES    = 400;
	localparam int DRAIN_CYCLES    = 60;
	localparam int TIMEOUT_NS      = 5_000_000;

	typedef logic [SAMPLE_BITS-1:0] sample_t;

	typedef struct packed {
		sample_t              a;
		sample_t              b;
		logic                 brake;
		logic                 rst;
		logic [TIME_BITS-1:0] now;
	} pedal_beat_t;

	typedef struct packed {
		sample_t  bmax;
		sample_t  bmin;
		logic [3:0] over;
		logic [3:0] under;
	} bound_track_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_wen;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  quiet = 1'b0;
	logic                  sink_hold = 1'b0;
	event                  stall_go;

	// predicted state of the block
	cfg_t                 cfg_mirror;
	bound_track_t         trk_a, trk_b;
	logic                 cal_on, mm_on, brk_on;
	logic [TIME_BITS-1:0] mm_at, brk_at;

	pedal_beat_t beat_queue[$];
	out_res_t    want_results[$];
	int          n_results = 0;
	int          n_errors = 0;

	// stimulus generator state
	int                   gen_lo = BOUND_MIN_RESET;
	int                   gen_hi = BOUND_MAX_RESET;
	int                   run_left = 0;
	int                   run_val = 0;
	logic [TIME_BITS-1:0] clock_ms = '0;

	dpsp_in_if #(.SAMPLE_BITS(SAMPLE_BITS), .TIME_BITS(TIME_BITS)) sample_ch();
	dpsp_out_if result_ch();

	dual_pedal_sensor_plausibility #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.TIME_BITS  (TIME_BITS)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.sample_ch(sample_ch),
		.result_ch(result_ch),
		.cfg_wen  (cfg_wen),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #(HALF_PERIOD) clk = ~clk;

	function automatic bound_track_t track_bounds(bound_track_t t, sample_t x);
		if (x > t.bmax) begin
			if (t.over >= cfg_mirror.confirm_count) begin
				t.bmax = x;
				t.over = '0;
			end else begin
				t.over = t.over + 4'd1;
			end
			t.under = '0;
		end else if (x < t.bmin) begin
			if (t.under >= cfg_mirror.confirm_count) begin
				t.bmin = x;
				t.under = '0;
			end else begin
				t.under = t.under + 4'd1;
			end
			t.over = '0;
		end else begin
			t.over = '0;
			t.under = '0;
		end
		return t;
	endfunction

	function automatic logic [PCT_W-1:0] position_percent(bound_track_t t, sample_t x);
		int unsigned mx, mn, xv, span, prod, cut_lo, cut_hi, hi, lo;
		mx = 32'(t.bmax);
		mn = 32'(t.bmin);
		xv = 32'(x);
		span = (mx >= mn) ? mx - mn : 0;
		prod = span * 32'(cfg_mirror.deadzone_percent);
		// low end rounds the cut down, high end rounds it up
		cut_lo = prod / 100;
		cut_hi = (prod + 99) / 100;
		hi = (mx >= cut_hi) ? mx - cut_hi : 0;
		lo = mn + cut_lo;
		if (xv <= lo)
			return '0;
		if (xv >= hi)
			return PCT_FULL;
		return PCT_W'((100 * (xv - lo)) / (hi - lo));
	endfunction

	function automatic out_res_t pedal_predict(pedal_beat_t bt);
		out_res_t         r;
		logic [PCT_W-1:0] pa, pb, avg, diff;
		// reset switch clears before this beat's checks
		if (bt.rst) begin
			cal_on = 1'b0;
			mm_on = 1'b0;
			brk_on = 1'b0;
		end
		trk_a = track_bounds(trk_a, bt.a);
		trk_b = track_bounds(trk_b, bt.b);
		pa = position_percent(trk_a, bt.a);
		pb = position_percent(trk_b, bt.b);
		avg = PCT_W'(({1'b0, pa} + {1'b0, pb}) >> 1);
		diff = (pa >= pb) ? pa - pb : pb - pa;
		if (diff > cfg_mirror.mismatch_limit) begin
			mm_on = 1'b1;
			mm_at = bt.now;
		end else if (mm_on && (bt.now - mm_at) > TIME_BITS'(cfg_mirror.hold_time_ms)) begin
			mm_on = 1'b0;
		end
		if (bt.brake && avg >= cfg_mirror.brake_pedal_limit) begin
			brk_on = 1'b1;
			brk_at = bt.now;
		end else if (brk_on && (bt.now - brk_at) > TIME_BITS'(cfg_mirror.hold_time_ms)) begin
			brk_on = 1'b0;
		end
		r.implausible     = cal_on | mm_on | brk_on | cfg_mirror.testing_mode;
		r.pedal_out       = r.implausible ? '0 : avg;
		r.average_percent = avg;
		r.percent_a       = pa;
		r.percent_b       = pb;
		r.mismatch_flag   = mm_on;
		r.brake_flag      = brk_on;
		r.calibrating     = cal_on;
		return r;
	endfunction

	task automatic report_error(string what);
		$display("%0t ns: result %0d: %s", $time, n_results, what);
		n_errors++;
	endtask

	task automatic check_field(string name, int got, int want);
		if (got != want)
			report_error($sformatf("%s got %0d, expected %0d", name, got, want));
	endtask

	function automatic void push_beat(int a, int b, bit brake, bit rst, logic [TIME_BITS-1:0] now);
		pedal_beat_t bt;
		bt.a = sample_t'(a);
		bt.b = sample_t'(b);
		bt.brake = brake;
		bt.rst = rst;
		bt.now = now;
		beat_queue.push_back(bt);
	endfunction

	function automatic pedal_beat_t random_beat();
		pedal_beat_t bt;
		int          a, b;
		// occasional noise beat: any value in any field
		if ($urandom_range(0, 99) < 4) begin
			bt.a = sample_t'($urandom_range(0, SAMPLE_MAX));
			bt.b = sample_t'($urandom_range(0, SAMPLE_MAX));
			bt.brake = 1'($urandom_range(0, 1));
			bt.rst = 1'($urandom_range(0, 1));
			bt.now = $urandom();
			return bt;
		end
		// start a run of out-of-range samples to push a bound outward
		if (run_left == 0 && $urandom_range(0, 99) < 4) begin
			run_left = $urandom_range(1, 17);
			if ($urandom_range(0, 1)) begin
				gen_hi = gen_hi + int'($urandom_range(1, 120));
				if (gen_hi > SAMPLE_MAX)
					gen_hi = SAMPLE_MAX;
				run_val = gen_hi;
			end else begin
				gen_lo = gen_lo - int'($urandom_range(1, 120));
				if (gen_lo < 0)
					gen_lo = 0;
				run_val = gen_lo;
			end
		end
		if (run_left > 0) begin
			a = run_val;
			run_left--;
		end else begin
			a = $urandom_range(gen_lo, gen_hi);
		end
		if ($urandom_range(0, 99) < 6)
			b = $urandom_range(gen_lo, gen_hi);
		else
			b = a + int'($urandom_range(0, 24)) - 12;
		if (b < 0)
			b = 0;
		if (b > SAMPLE_MAX)
			b = SAMPLE_MAX;
		bt.a = sample_t'(a);
		bt.b = sample_t'(b);
		bt.brake = ($urandom_range(0, 99) < 8);
		bt.rst = ($urandom_range(0, 99) < 3);
		if ($urandom_range(0, 99) < 10)
			clock_ms = clock_ms + $urandom_range(0, 4000);
		else
			clock_ms = clock_ms + $urandom_range(0, 300);
		bt.now = clock_ms;
		return bt;
	endfunction

	task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_wen <= 1'b0;
		case (idx)
			REG_DEADZONE:    cfg_mirror.deadzone_percent = value[DZ_W-1:0];
			REG_MISMATCH:    cfg_mirror.mismatch_limit = value[LIM_W-1:0];
			REG_CONFIRM:     cfg_mirror.confirm_count = value[CONFIRM_W-1:0];
			REG_BRAKE_LIMIT: cfg_mirror.brake_pedal_limit = value[LIM_W-1:0];
			REG_HOLD:        cfg_mirror.hold_time_ms = value[HOLD_W-1:0];
			REG_TESTING:     cfg_mirror.testing_mode = value[0];
			default: ;
		endcase
	endtask

	task automatic program_regs(int dz, int mm, int conf, int brk, int hold, int tst);
		set_reg(REG_DEADZONE, CFG_DATA_W'(dz));
		set_reg(REG_MISMATCH, CFG_DATA_W'(mm));
		set_reg(REG_CONFIRM, CFG_DATA_W'(conf));
		set_reg(REG_BRAKE_LIMIT, CFG_DATA_W'(brk));
		set_reg(REG_HOLD, CFG_DATA_W'(hold));
		set_reg(REG_TESTING, CFG_DATA_W'(tst));
	endtask

	// hold the sender back until every beat is out and every result is in
	task automatic drain_all();
		while (beat_queue.size() != 0 || sample_ch.valid || want_results.size() != 0)
			@(posedge clk);
	endtask

	// sample side: offer queued beats, predict on each accepted one
	always @(posedge clk) begin
		pedal_beat_t cur, nxt;
		logic        hold;
		if (!arst_n) begin
			sample_ch.valid <= 1'b0;
		end else begin
			hold = sample_ch.valid && !sample_ch.ready;
			if (sample_ch.valid && sample_ch.ready) begin
				cur.a = sample_ch.sample_a;
				cur.b = sample_ch.sample_b;
				cur.brake = sample_ch.brake_pressed;
				cur.rst = sample_ch.reset_pressed;
				cur.now = sample_ch.now_ms;
				want_results.push_back(pedal_predict(cur));
			end
			if (!hold) begin
				if (beat_queue.size() != 0 && (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
					nxt = beat_queue.pop_front();
					sample_ch.valid <= 1'b1;
					sample_ch.sample_a <= nxt.a;
					sample_ch.sample_b <= nxt.b;
					sample_ch.brake_pressed <= nxt.brake;
					sample_ch.reset_pressed <= nxt.rst;
					sample_ch.now_ms <= nxt.now;
				end else begin
					sample_ch.valid <= 1'b0;
				end
			end
		end
	end

	// result side: compare each beat with the oldest prediction
	always @(posedge clk) begin
		out_res_t got, want;
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				got.implausible     = result_ch.implausible;
				got.pedal_out       = result_ch.pedal_out;
				got.average_percent = result_ch.average_percent;
				got.percent_a       = result_ch.percent_a;
				got.percent_b       = result_ch.percent_b;
				got.mismatch_flag   = result_ch.mismatch_flag;
				got.brake_flag      = result_ch.brake_flag;
				got.calibrating     = result_ch.calibrating;
				if (want_results.size() == 0) begin
					report_error("result beat with nothing expected");
				end else begin
					want = want_results.pop_front();
					check_field("implausible", int'(got.implausible),
						int'(want.implausible));
					check_field("pedal_out", int'(got.pedal_out), int'(want.pedal_out));
					check_field("average_percent", int'(got.average_percent),
						int'(want.average_percent));
					check_field("percent_a", int'(got.percent_a), int'(want.percent_a));
					check_field("percent_b", int'(got.percent_b), int'(want.percent_b));
					check_field("mismatch_flag", int'(got.mismatch_flag),
						int'(want.mismatch_flag));
					check_field("brake_flag", int'(got.brake_flag), int'(want.brake_flag));
					check_field("calibrating", int'(got.calibrating),
						int'(want.calibrating));
				end
				n_results++;
			end
			result_ch.ready <= !sink_hold && (quiet || $urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	// long back-pressure stretch on the result side
	always begin
		@(stall_go);
		@(posedge clk);
		sink_hold <= 1'b1;
		repeat (STALL_CYCLES) @(posedge clk);
		sink_hold <= 1'b0;
	end

	initial begin
		arst_n = 1'b0;
		cfg_wen = 1'b0;
		cfg_index = REG_DEADZONE;
		cfg_data = '0;
		sample_ch.valid = 1'b0;
		sample_ch.sample_a = '0;
		sample_ch.sample_b = '0;
		sample_ch.brake_pressed = 1'b0;
		sample_ch.reset_pressed = 1'b0;
		sample_ch.now_ms = '0;
		result_ch.ready = 1'b0;

		cfg_mirror = CFG_RESET;
		trk_a.bmax = sample_t'(BOUND_MAX_RESET);
		trk_a.bmin = sample_t'(BOUND_MIN_RESET);
		trk_a.over = '0;
		trk_a.under = '0;
		trk_b = trk_a;
		cal_on = 1'b1;
		mm_on = 1'b0;
		brk_on = 1'b0;
		mm_at = '0;
		brk_at = '0;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// defaults: calibration, bound edges, hold timers, wrap, bound moves
		push_beat(0, SAMPLE_MAX, 0, 0, 32'd0);
		push_beat(SAMPLE_MAX, 0, 1, 0, 32'd10);
		push_beat(1300, 1300, 0, 1, 32'd20);
		push_beat(600, 600, 0, 0, 32'd30);
		push_beat(2000, 2000, 0, 0, 32'd40);
		push_beat(600, 2000, 0, 0, 32'd100);
		push_beat(1300, 1300, 0, 0, 32'd600);
		push_beat(1300, 1300, 0, 0, 32'd601);
		push_beat(1800, 1800, 1, 0, 32'd700);
		push_beat(1800, 1800, 0, 0, 32'd1201);
		push_beat(600, 1900, 0, 0, 32'hFFFF_FF00);
		push_beat(1000, 1000, 0, 0, 32'h0000_00F0);
		push_beat(1000, 1000, 0, 0, 32'h0000_0110);
		for (int k = 0; k < 3; k++)
			push_beat(3000, 3000, 0, 0, 32'h200 + k);
		for (int k = 0; k < 3; k++)
			push_beat(100, 100, 0, 0, 32'h300 + k);
		push_beat(700, 2900, 1, 1, 32'h400);
		drain_all();

		// widest deadzone, loosest mismatch limit, testing forced on
		program_regs(63, 127, 0, 0, 0, 1);
		push_beat(1500, 1500, 0, 0, 32'h500);
		push_beat(SAMPLE_MAX, 0, 1, 0, 32'h501);
		push_beat(0, 0, 0, 0, 32'h502);
		drain_all();

		program_regs(0, 0, 15, 100, 65535, 0);
		push_beat(1550, 1560, 1, 0, 32'h600);
		push_beat(SAMPLE_MAX, SAMPLE_MAX, 1, 0, 32'h601);
		clock_ms = 32'h1000;

		for (int ph = 0; ph < PHASES; ph++) begin
			drain_all();
			case (ph)
				0: program_regs(8, 10, 2, 5, 500, 0);
				3: program_regs(49, 100, 15, 100, 65535, 0);
				4: program_regs(0, 0, 0, 0, 0, 0);
				5: program_regs($urandom_range(50, 63), $urandom_range(0, 40),
					$urandom_range(0, 15), $urandom_range(0, 100), $urandom_range(0, 3000), 0);
				6: program_regs($urandom_range(0, 49), $urandom_range(0, 40),
					$urandom_range(0, 15), $urandom_range(0, 100), $urandom_range(0, 3000), 1);
				default: program_regs($urandom_range(0, 49), $urandom_range(0, 40),
					$urandom_range(0, 15), $urandom_range(0, 100), $urandom_range(0, 3000), 0);
			endcase
			quiet <= (ph == 3);
			// run the timestamp across the wrap
			if (ph == 5)
				clock_ms = 32'hFFFF_F000;
			if (ph == 2)
				-> stall_go;
			repeat (BEATS_PER_PHASE) beat_queue.push_back(random_beat());
		end

		drain_all();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (n_errors == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("testbench: errors");
		$finish;
	end

endmodule
